### src/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg: shared types and constants of the TGA colour-mapped RLE decoder
// Parser phases, sequencer states, result kinds and the header format codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_pkg;

  localparam int ADDR_W     = 24;
  localparam int HDR_LEN    = 18;
  localparam int PAL_BYTES  = 48;
  localparam int OUT_DATA_W = 104;

  // header field codes
  localparam logic [7:0] CMAP_PRESENT = 8'd1;
  localparam logic [7:0] TYPE_RAW     = 8'd1;
  localparam logic [7:0] TYPE_RLE     = 8'd9;
  localparam logic [7:0] MAP_LEN      = 8'd16;
  localparam logic [7:0] MAP_BITS     = 8'd24;
  localparam logic [7:0] PIX_BITS     = 8'd8;
  localparam logic [7:0] DESC_TOP     = 8'd32;
  localparam logic [7:0] DESC_BOTTOM  = 8'd0;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEADER,
    PH_IDSKIP,
    PH_PALETTE,
    PH_RAW,
    PH_RLEHDR,
    PH_RUNVAL,
    PH_LIT
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_RUN_A,
    SEQ_RUN_B
  } seq_t;

  typedef enum logic [2:0] {
    KIND_PIXEL    = 3'd0,
    KIND_PALETTE  = 3'd1,
    KIND_HDR_OK   = 3'd2,
    KIND_FMT_BAD  = 3'd3,
    KIND_SIZE_BAD = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    POS_NOP,
    POS_LOAD,
    POS_MUL,
    POS_STEP
  } pos_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              fin;
    logic              mul_done;
  } pos_stat_t;

  typedef struct packed {
    logic        fmt_ok;
    logic        size_ok;
    logic [15:0] width;
    logic [15:0] height;
    logic        top_down;
    logic        rle;
    logic [7:0]  id_len;
  } hdr_verdict_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr_a;
    logic [7:0]        value_a;
    logic [ADDR_W-1:0] addr_b;
    logic [7:0]        value_b;
    logic              b_valid;
    logic [15:0]       width;
    logic [15:0]       height;
    logic              last;
    logic              done;
  } item_t;

endpackage

`default_nettype wire

### src/tga_colormapped_rle_decoder.sv
// ----------------------------------------------------------------------------
// tga_colormapped_rle_decoder: colour-mapped TGA stream decoder
// Parses the header, passes out the 16-entry palette and decodes raw or RLE
// 8-bit pixels into writes at row-major addresses.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser         | tlast
//  --------+-----+-------------------------------+---------------+------------
//  in_     | in  | data_byte                     | start_of_file | -
//  out_    | out | addr/value a,b, b_valid, size | item_kind     | last_of_run
//
//  Header, ID, palette, raw and literal bytes are taken one per cycle while
//  the out_ slot is free. A run value byte holds in_tready low while its
//  pixels expand: the position unit advances one pixel per cycle while the
//  out_ slot is free, a result every two pixels. After the last palette
//  byte a bottom-up image runs shift-add steps to place the first row.
//  rst_n is synchronous; a stalled out_ item holds and blocks the next one.
//
`default_nettype none

module tga_colormapped_rle_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                         in_tuser,   // [0] start_of_file
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [23:0] addr_a, [31:24] value_a, [55:32] addr_b, [63:56] value_b,
  // [64] b_valid, [80:65] image_width, [96:81] image_height, [97] image_done
  output logic [tga_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [2:0]                              out_tuser,  // [2:0] item_kind
  output logic                                    out_tlast   // last_of_run
);
  import tga_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // parser and sequencer state
  phase_t            phase_r, phase_nxt;
  seq_t              seq_r, seq_nxt;
  logic [4:0]        hcount_r, hcount_nxt;
  logic [7:0]        id_left_r, id_left_nxt;
  logic [5:0]        pal_cnt_r, pal_cnt_nxt;
  logic [7:0]        pkt_left_r, pkt_left_nxt;
  logic              rle_r, rle_nxt;
  logic [7:0]        run_val_r, run_val_nxt;
  logic [ADDR_W-1:0] a_addr_r, a_addr_nxt;

  // result register
  logic              out_valid_r;
  item_t             out_r;
  item_t             item_nxt;
  logic              out_load;

  // datapath hookup
  logic              slot_free;
  logic              accept;
  phase_t            ph;
  logic [4:0]        hc;
  logic [7:0]        left_n;
  logic              hdr_we;
  hdr_verdict_t      verdict;
  pos_op_t           pos_op;
  pos_stat_t         pos_stat;

  tga_hdr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_hdr (
    .clk       (clk),
    .wr_en     (hdr_we),
    .wr_idx    (hc),
    .wr_data   (in_tdata),
    .last_byte (in_tdata),
    .verdict   (verdict)
  );

  tga_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (pos_op),
    .ld_width    (verdict.width[WW-1:0]),
    .ld_height   (verdict.height[HW-1:0]),
    .ld_top_down (verdict.top_down),
    .stat        (pos_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      seq_r       <= SEQ_IDLE;
      hcount_r    <= '0;
      id_left_r   <= '0;
      pal_cnt_r   <= '0;
      pkt_left_r  <= '0;
      rle_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      seq_r      <= seq_nxt;
      hcount_r   <= hcount_nxt;
      id_left_r  <= id_left_nxt;
      pal_cnt_r  <= pal_cnt_nxt;
      pkt_left_r <= pkt_left_nxt;
      rle_r      <= rle_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    run_val_r <= run_val_nxt;
    a_addr_r  <= a_addr_nxt;
    if (out_load) begin
      out_r <= item_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    seq_nxt      = seq_r;
    hcount_nxt   = hcount_r;
    id_left_nxt  = id_left_r;
    pal_cnt_nxt  = pal_cnt_r;
    pkt_left_nxt = pkt_left_r;
    rle_nxt      = rle_r;
    run_val_nxt  = run_val_r;
    a_addr_nxt   = a_addr_r;
    item_nxt     = '0;
    out_load     = 1'b0;
    hdr_we       = 1'b0;
    pos_op       = POS_NOP;
    left_n       = pkt_left_r - 8'd1;

    slot_free = !out_valid_r || out_tready;
    in_tready = (seq_r == SEQ_IDLE) && slot_free;
    accept    = in_tvalid && in_tready;

    // start of file overrides whatever phase we are in
    ph = in_tuser[0] ? PH_HEADER : phase_r;
    hc = in_tuser[0] ? 5'd0 : hcount_r;

    case (seq_r)
      SEQ_IDLE: begin
        if (accept) begin
          case (ph)
            PH_HEADER: begin
              phase_nxt = PH_HEADER;
              if (hc == 5'(HDR_LEN - 1)) begin
                // final header byte: give the verdict with the sizes
                hcount_nxt      = '0;
                out_load        = 1'b1;
                item_nxt.width  = verdict.width;
                item_nxt.height = verdict.height;
                item_nxt.last   = 1'b1;
                if (!verdict.fmt_ok) begin
                  item_nxt.kind = KIND_FMT_BAD;
                  phase_nxt     = PH_WAIT;
                end else if (!verdict.size_ok) begin
                  item_nxt.kind = KIND_SIZE_BAD;
                  phase_nxt     = PH_WAIT;
                end else begin
                  item_nxt.kind = KIND_HDR_OK;
                  pos_op        = POS_LOAD;
                  rle_nxt       = verdict.rle;
                  id_left_nxt   = verdict.id_len;
                  pal_cnt_nxt   = '0;
                  phase_nxt     = (verdict.id_len != 8'd0) ? PH_IDSKIP : PH_PALETTE;
                end
              end else begin
                hdr_we     = 1'b1;
                hcount_nxt = hc + 5'd1;
              end
            end
            PH_IDSKIP: begin
              id_left_nxt = id_left_r - 8'd1;
              if (id_left_r == 8'd1) begin
                phase_nxt = PH_PALETTE;
              end
            end
            PH_PALETTE: begin
              out_load         = 1'b1;
              item_nxt.kind    = KIND_PALETTE;
              item_nxt.addr_a  = ADDR_W'(pal_cnt_r);
              item_nxt.value_a = in_tdata;
              item_nxt.last    = 1'b1;
              pal_cnt_nxt      = pal_cnt_r + 6'd1;
              if (pal_cnt_r == 6'(PAL_BYTES - 1)) begin
                // place the first row before any pixel arrives
                phase_nxt = rle_r ? PH_RLEHDR : PH_RAW;
                seq_nxt   = SEQ_MUL;
              end
            end
            PH_RAW: begin
              pos_op           = POS_STEP;
              out_load         = 1'b1;
              item_nxt.kind    = KIND_PIXEL;
              item_nxt.addr_a  = pos_stat.addr;
              item_nxt.value_a = in_tdata;
              item_nxt.last    = 1'b1;
              item_nxt.done    = pos_stat.fin;
              if (pos_stat.fin) begin
                phase_nxt = PH_WAIT;
              end
            end
            PH_RLEHDR: begin
              pkt_left_nxt = {1'b0, in_tdata[6:0]} + 8'd1;
              phase_nxt    = in_tdata[7] ? PH_RUNVAL : PH_LIT;
            end
            PH_RUNVAL: begin
              run_val_nxt = in_tdata;
              phase_nxt   = PH_RLEHDR;
              seq_nxt     = SEQ_RUN_A;
            end
            PH_LIT: begin
              pkt_left_nxt     = left_n;
              phase_nxt        = (left_n == 8'd0) ? PH_RLEHDR : PH_LIT;
              pos_op           = POS_STEP;
              out_load         = 1'b1;
              item_nxt.kind    = KIND_PIXEL;
              item_nxt.addr_a  = pos_stat.addr;
              item_nxt.value_a = in_tdata;
              item_nxt.last    = 1'b1;
              item_nxt.done    = pos_stat.fin;
              if (pos_stat.fin) begin
                phase_nxt = PH_WAIT;
              end
            end
            default: begin
              // waiting for a start of file: drop the byte
            end
          endcase
        end
      end
      SEQ_MUL: begin
        if (pos_stat.mul_done) begin
          seq_nxt = SEQ_IDLE;
        end else begin
          pos_op = POS_MUL;
        end
      end
      SEQ_RUN_A: begin
        if (slot_free) begin
          pos_op       = POS_STEP;
          pkt_left_nxt = left_n;
          if (pos_stat.fin || (left_n == 8'd0)) begin
            // odd pixel or image end: single write closes the run
            out_load         = 1'b1;
            item_nxt.kind    = KIND_PIXEL;
            item_nxt.addr_a  = pos_stat.addr;
            item_nxt.value_a = run_val_r;
            item_nxt.last    = 1'b1;
            item_nxt.done    = pos_stat.fin;
            seq_nxt          = SEQ_IDLE;
            if (pos_stat.fin) begin
              phase_nxt = PH_WAIT;
            end
          end else begin
            a_addr_nxt = pos_stat.addr;
            seq_nxt    = SEQ_RUN_B;
          end
        end
      end
      SEQ_RUN_B: begin
        if (slot_free) begin
          pos_op           = POS_STEP;
          pkt_left_nxt     = left_n;
          out_load         = 1'b1;
          item_nxt.kind    = KIND_PIXEL;
          item_nxt.addr_a  = a_addr_r;
          item_nxt.value_a = run_val_r;
          item_nxt.addr_b  = pos_stat.addr;
          item_nxt.value_b = run_val_r;
          item_nxt.b_valid = 1'b1;
          item_nxt.last    = pos_stat.fin || (left_n == 8'd0);
          item_nxt.done    = pos_stat.fin;
          seq_nxt          = (pos_stat.fin || (left_n == 8'd0)) ? SEQ_IDLE : SEQ_RUN_A;
          if (pos_stat.fin) begin
            phase_nxt = PH_WAIT;
          end
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {6'd0, out_r.done, out_r.height, out_r.width, out_r.b_valid,
                       out_r.value_b, out_r.addr_b, out_r.value_a, out_r.addr_a};

`ifndef SYNTHESIS
  a_pair_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.b_valid) |-> (out_r.kind == KIND_PIXEL))
    else $error("second pixel slot set on a non-pixel item");

  a_done_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && item_nxt.done) |=> (phase_r == PH_WAIT))
    else $error("parser still active after final pixel");

  a_run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    ((seq_r == SEQ_RUN_A) || (seq_r == SEQ_RUN_B)) |->
      ((pkt_left_r != 8'd0) && (phase_r == PH_RLEHDR)))
    else $error("run expansion without pixels left");
`endif

endmodule

`default_nettype wire

### src/tga_hdr.sv
// ----------------------------------------------------------------------------
// tga_hdr: header byte store and format/size check
// Holds header bytes 0..16; the check takes byte 17 live from the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_hdr #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [4:0]            wr_idx,
  input  wire logic [7:0]            wr_data,
  input  wire logic [7:0]            last_byte,
  output tga_pkg::hdr_verdict_t      verdict
);
  import tga_pkg::*;

  logic [7:0]  bytes_r [HDR_LEN-1];
  logic [15:0] w;
  logic [15:0] h;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    w = {bytes_r[13], bytes_r[12]};
    h = {bytes_r[15], bytes_r[14]};
    verdict.width    = w;
    verdict.height   = h;
    verdict.fmt_ok   = (bytes_r[1] == CMAP_PRESENT) &&
                       ((bytes_r[2] == TYPE_RAW) || (bytes_r[2] == TYPE_RLE)) &&
                       (bytes_r[3] == 8'd0) && (bytes_r[4] == 8'd0) &&
                       (bytes_r[5] == MAP_LEN) && (bytes_r[6] == 8'd0) &&
                       (bytes_r[7] == MAP_BITS) && (bytes_r[16] == PIX_BITS) &&
                       ((last_byte == DESC_TOP) || (last_byte == DESC_BOTTOM));
    verdict.size_ok  = (w != 16'd0) && (h != 16'd0) &&
                       ({1'b0, w} <= 17'(MAX_WIDTH)) && ({1'b0, h} <= 17'(MAX_HEIGHT));
    verdict.top_down = (last_byte == DESC_TOP);
    verdict.rle      = (bytes_r[2] == TYPE_RLE);
    verdict.id_len   = bytes_r[0];
  end

endmodule

`default_nettype wire

### src/tga_pos.sv
// ----------------------------------------------------------------------------
// tga_pos: pixel position unit
// One shared adder moves the row base: shift-add steps build the start row
// of a bottom-up image, then each step into a new row adds or subtracts the width.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_pos #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  tga_pkg::pos_op_t                          op,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       ld_width,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]      ld_height,
  input  wire logic                                 ld_top_down,
  output tga_pkg::pos_stat_t                        stat
);
  import tga_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]     col_r;
  logic [WW-1:0]     width_r;
  logic [HW-1:0]     rows_r;
  logic              td_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] mcand_r;
  logic [HW-1:0]     mult_r;

  logic [WW-1:0]     col_inc;
  logic              wrap;
  logic [ADDR_W-1:0] operand;
  logic [ADDR_W-1:0] sum;

  always_comb begin
    col_inc = col_r + 1'b1;
    wrap    = (col_inc >= width_r);
    if (op == POS_MUL) begin
      operand = mcand_r;
    end else if (td_r) begin
      operand = ADDR_W'(width_r);
    end else begin
      operand = ADDR_W'(0) - ADDR_W'(width_r);
    end
    sum           = base_r + operand;
    stat.addr     = base_r + ADDR_W'(col_r);
    stat.fin      = wrap && (rows_r == HW'(1));
    stat.mul_done = (mult_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      width_r <= '0;
      rows_r  <= '0;
      td_r    <= 1'b0;
      base_r  <= '0;
      mcand_r <= '0;
      mult_r  <= '0;
    end else begin
      case (op)
        POS_LOAD: begin
          col_r   <= '0;
          width_r <= ld_width;
          rows_r  <= ld_height;
          td_r    <= ld_top_down;
          base_r  <= '0;
          mcand_r <= ADDR_W'(ld_width);
          mult_r  <= ld_top_down ? '0 : ld_height - 1'b1;
        end
        POS_MUL: begin
          if (mult_r[0]) begin
            base_r <= sum;
          end
          mcand_r <= mcand_r << 1;
          mult_r  <= mult_r >> 1;
        end
        POS_STEP: begin
          if (wrap) begin
            col_r  <= '0;
            base_r <= sum;
            rows_r <= rows_r - 1'b1;
          end else begin
            col_r <= col_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the colour-mapped TGA RLE decoder
// Feeds TGA byte streams (good files, truncated files, bad headers and loose
// bytes) into the decoder and compares every result item against a
// scoreboard that tracks the header, palette and pixel decode itself.
// ----------------------------------------------------------------------------

module tb_top;
  import tga_pkg::*;

  localparam int MAX_W     = 4096;
  localparam int MAX_H     = 4096;
  localparam int MAX_SHOWN = 10;
  localparam int QUIET_MAX = 4000;   // cycles with no handshake at all
  localparam int HOLD_LEN  = 400;    // long receiver hold-off
  localparam int RAND_BYTES = 420;

  // header byte offsets
  localparam int HB_IDLEN    = 0;
  localparam int HB_CMAP     = 1;
  localparam int HB_TYPE     = 2;
  localparam int HB_ORG_LO   = 3;
  localparam int HB_ORG_HI   = 4;
  localparam int HB_LEN_LO   = 5;
  localparam int HB_LEN_HI   = 6;
  localparam int HB_MAP_BITS = 7;
  localparam int HB_W_LO     = 12;
  localparam int HB_W_HI     = 13;
  localparam int HB_H_LO     = 14;
  localparam int HB_H_HI     = 15;
  localparam int HB_PIX_BITS = 16;
  localparam int HB_DESC     = 17;

  typedef logic [7:0] hdr_t [HDR_LEN];

  // --------------------------------------------------------------------------
  // Scoreboard: decodes the byte stream on its own and keeps the pending
  // result items in order.
  // --------------------------------------------------------------------------
  class tga_scoreboard;
    item_t       expected_q[$];
    item_t       fresh[$];
    int          errors;
    phase_t      ph;
    int unsigned hdr_cnt;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  id_left;
    int unsigned pal_cnt;
    logic [15:0] wid, hgt, col, row, rows_left;
    logic        top, rle, literal;
    logic [7:0]  pkt_left;

    function new();
      errors    = 0;
      ph        = PH_WAIT;
      hdr_cnt   = 0;
      id_left   = '0;
      pal_cnt   = 0;
      wid       = '0;
      hgt       = '0;
      col       = '0;
      row       = '0;
      rows_left = '0;
      top       = 1'b0;
      rle       = 1'b0;
      literal   = 1'b0;
      pkt_left  = '0;
    endfunction

    function void add(kind_t k, logic [23:0] aa, logic [7:0] va, logic [23:0] ab,
                      logic [7:0] vb, logic bv, logic [15:0] w, logic [15:0] h,
                      logic done);
      item_t it;
      it.kind    = k;
      it.addr_a  = aa;
      it.value_a = va;
      it.addr_b  = ab;
      it.value_b = vb;
      it.b_valid = bv;
      it.width   = w;
      it.height  = h;
      it.last    = 1'b0;
      it.done    = done;
      fresh.push_back(it);
    endfunction

    // address of the current pixel, then step; fin on the final pixel
    function logic [23:0] next_addr(output logic fin);
      int unsigned p;
      fin = 1'b0;
      p   = row * wid + col;
      col = col + 16'd1;
      if (col >= wid) begin
        col       = '0;
        row       = top ? row + 16'd1 : row - 16'd1;
        rows_left = rows_left - 16'd1;
        if (rows_left == 0) begin
          fin = 1'b1;
          ph  = PH_WAIT;
        end
      end
      return p[23:0];
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      logic [15:0] w, h;
      logic        fmt_ok, fin;
      logic [23:0] a, a2;
      int unsigned left;
      fresh.delete();
      fin = 1'b0;
      if (sof) begin
        ph      = PH_HEADER;
        hdr_cnt = 0;
      end
      case (ph)
        PH_HEADER: begin
          hdr[hdr_cnt] = b;
          hdr_cnt++;
          if (hdr_cnt == HDR_LEN) begin
            hdr_cnt = 0;
            w = {hdr[HB_W_HI], hdr[HB_W_LO]};
            h = {hdr[HB_H_HI], hdr[HB_H_LO]};
            fmt_ok = hdr[HB_CMAP] == CMAP_PRESENT &&
                     (hdr[HB_TYPE] == TYPE_RAW || hdr[HB_TYPE] == TYPE_RLE) &&
                     hdr[HB_ORG_LO] == 8'd0 && hdr[HB_ORG_HI] == 8'd0 &&
                     hdr[HB_LEN_LO] == MAP_LEN && hdr[HB_LEN_HI] == 8'd0 &&
                     hdr[HB_MAP_BITS] == MAP_BITS && hdr[HB_PIX_BITS] == PIX_BITS &&
                     (hdr[HB_DESC] == DESC_TOP || hdr[HB_DESC] == DESC_BOTTOM);
            ph = PH_WAIT;
            if (!fmt_ok) begin
              add(KIND_FMT_BAD, '0, '0, '0, '0, 1'b0, w, h, 1'b0);
            end else if (w == 0 || h == 0 || w > MAX_W || h > MAX_H) begin
              add(KIND_SIZE_BAD, '0, '0, '0, '0, 1'b0, w, h, 1'b0);
            end else begin
              wid     = w;
              hgt     = h;
              top     = hdr[HB_DESC] == DESC_TOP;
              rle     = hdr[HB_TYPE] == TYPE_RLE;
              id_left = hdr[HB_IDLEN];
              pal_cnt = 0;
              ph      = (id_left != 0) ? PH_IDSKIP : PH_PALETTE;
              add(KIND_HDR_OK, '0, '0, '0, '0, 1'b0, w, h, 1'b0);
            end
          end
        end
        PH_IDSKIP: begin
          id_left = id_left - 8'd1;
          if (id_left == 0) ph = PH_PALETTE;
        end
        PH_PALETTE: begin
          add(KIND_PALETTE, 24'(pal_cnt), b, '0, '0, 1'b0, '0, '0, 1'b0);
          pal_cnt++;
          if (pal_cnt == PAL_BYTES) begin
            col       = '0;
            row       = top ? 16'd0 : hgt - 16'd1;
            rows_left = hgt;
            pkt_left  = '0;
            literal   = 1'b0;
            ph        = rle ? PH_RLEHDR : PH_RAW;
          end
        end
        PH_RAW: begin
          a = next_addr(fin);
          add(KIND_PIXEL, a, b, '0, '0, 1'b0, '0, '0, fin);
        end
        PH_RLEHDR: begin
          pkt_left = {1'b0, b[6:0]} + 8'd1;
          literal  = !b[7];
          ph       = literal ? PH_LIT : PH_RUNVAL;
        end
        PH_RUNVAL: begin
          // two pixels per item; stop at the image end
          left = pkt_left;
          ph   = PH_RLEHDR;
          while (left > 0 && !fin) begin
            a = next_addr(fin);
            left--;
            if (fin || left == 0) begin
              add(KIND_PIXEL, a, b, '0, '0, 1'b0, '0, '0, fin);
            end else begin
              a2 = next_addr(fin);
              left--;
              add(KIND_PIXEL, a, b, a2, b, 1'b1, '0, '0, fin);
            end
          end
          pkt_left = '0;
        end
        PH_LIT: begin
          pkt_left = pkt_left - 8'd1;
          if (pkt_left == 0) ph = PH_RLEHDR;
          a = next_addr(fin);
          add(KIND_PIXEL, a, b, '0, '0, 1'b0, '0, '0, fin);
        end
        default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) expected_q.push_back(fresh[i]);
    endfunction

    function string fmt_item(item_t it);
      return $sformatf("kind=%0d aa=%06h va=%02h ab=%06h vb=%02h bv=%b w=%0d h=%0d last=%b done=%b",
                       it.kind, it.addr_a, it.value_a, it.addr_b, it.value_b,
                       it.b_valid, it.width, it.height, it.last, it.done);
    endfunction

    function void check_item(item_t got);
      item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("unexpected item: %s", fmt_item(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.addr_a !== want.addr_a ||
          got.value_a !== want.value_a || got.addr_b !== want.addr_b ||
          got.value_b !== want.value_b || got.b_valid !== want.b_valid ||
          got.width !== want.width || got.height !== want.height ||
          got.last !== want.last || got.done !== want.done) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected: %s", fmt_item(want));
          $display("  actual:   %s", fmt_item(got));
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] data_byte
  logic [0:0]  in_tuser = '0;     // [0] start_of_file
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [23:0] addr_a, [31:24] value_a, [55:32] addr_b, [63:56] value_b,
  // [64] b_valid, [80:65] image_width, [96:81] image_height, [97] image_done
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]  out_tuser;         // [2:0] item_kind
  logic        out_tlast;         // last_of_run

  tga_scoreboard sb = new();
  item_t         seen_item;
  int            tx_idle = 13;    // percent of cycles the sender idles
  int            rx_idle = 74;    // percent of cycles the receiver stalls
  int            sent_bytes = 0;
  bit            hold_req = 1'b0; // ask the receiver for a long hold-off
  int            hold_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  tga_colormapped_rle_decoder #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a long stretch on request.
  // Only this process drives out_tready.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Note the input item
  // first; its results can only follow anything already pending.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) begin
        seen_item.kind    = kind_t'(out_tuser);
        seen_item.addr_a  = out_tdata[23:0];
        seen_item.value_a = out_tdata[31:24];
        seen_item.addr_b  = out_tdata[55:32];
        seen_item.value_b = out_tdata[63:56];
        seen_item.b_valid = out_tdata[64];
        seen_item.width   = out_tdata[80:65];
        seen_item.height  = out_tdata[96:81];
        seen_item.done    = out_tdata[97];
        seen_item.last    = out_tlast;
        sb.check_item(seen_item);
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles", QUIET_MAX);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks. All are entered and left at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  // drop valid and hold until every pending result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // well-formed header; the x/y origin bytes stay random
  function automatic hdr_t good_header(int w, int h, bit rle_img, bit top_img, int idlen);
    hdr_t hh;
    foreach (hh[i]) hh[i] = 8'($urandom);
    hh[HB_IDLEN]    = 8'(idlen);
    hh[HB_CMAP]     = CMAP_PRESENT;
    hh[HB_TYPE]     = rle_img ? TYPE_RLE : TYPE_RAW;
    hh[HB_ORG_LO]   = 8'd0;
    hh[HB_ORG_HI]   = 8'd0;
    hh[HB_LEN_LO]   = MAP_LEN;
    hh[HB_LEN_HI]   = 8'd0;
    hh[HB_MAP_BITS] = MAP_BITS;
    hh[HB_W_LO]     = w[7:0];
    hh[HB_W_HI]     = w[15:8];
    hh[HB_H_LO]     = h[7:0];
    hh[HB_H_HI]     = h[15:8];
    hh[HB_PIX_BITS] = PIX_BITS;
    hh[HB_DESC]     = top_img ? DESC_TOP : DESC_BOTTOM;
    return hh;
  endfunction

  task automatic send_header(input hdr_t hh);
    send_byte(hh[0], 1'b1);
    for (int i = 1; i < HDR_LEN; i++) send_byte(hh[i], 1'b0);
  endtask

  // ID field then the palette
  task automatic send_prefix(input int idlen);
    repeat (idlen) send_byte(8'($urandom), 1'b0);
    repeat (PAL_BYTES) send_byte(8'($urandom), 1'b0);
  endtask

  // pixel data covering npix pixels; RLE mixes runs and literals, and the
  // last packet may run past npix
  task automatic send_pixels(input bit rle_img, input int npix);
    int left, cnt;
    left = npix;
    if (!rle_img) begin
      repeat (npix) send_byte(8'($urandom), 1'b0);
    end else begin
      while (left > 0) begin
        if ($urandom_range(7) == 0) cnt = $urandom_range(1, 128);
        else cnt = $urandom_range(1, (left < 128) ? left : 128);
        if ($urandom_range(1)) begin
          send_byte({1'b1, 7'(cnt - 1)}, 1'b0);
          send_byte(8'($urandom), 1'b0);
        end else begin
          if (cnt > left + 2) cnt = left + 2;
          send_byte({1'b0, 7'(cnt - 1)}, 1'b0);
          repeat (cnt) send_byte(8'($urandom), 1'b0);
        end
        left -= cnt;
      end
    end
  endtask

  task automatic send_file(input int w, input int h, input bit rle_img, input bit top_img,
                           input int idlen, input int npix);
    send_header(good_header(w, h, rle_img, top_img, idlen));
    send_prefix(idlen);
    send_pixels(rle_img, npix);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    hdr_t hh;
    int   w, h, r, npix;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // loose bytes before any start are dropped
    repeat (3) send_byte(8'($urandom), 1'b0);
    // small raw bottom-up image with trailing bytes past the end
    send_file(3, 2, 1'b0, 1'b0, 0, 8);
    // single pixel image: the first pixel is the last
    send_file(1, 1, 1'b0, 1'b1, 0, 1);
    wait_drained();

    // long receiver hold-off: results back up and the input stalls
    hold_req = 1'b1;
    send_file(6, 5, 1'b0, 1'b1, 2, 30);
    wait_drained();

    // full 128-pixel run: 64 items from one byte
    send_header(good_header(16, 8, 1'b1, 1'b1, 0));
    send_prefix(0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);

    // literal, short run, then a run that overshoots the image end
    send_header(good_header(5, 3, 1'b1, 1'b0, 3));
    send_prefix(3);
    send_byte(8'h02, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    repeat (2) send_byte(8'($urandom), 1'b0);

    // largest image, bottom-up: first row at the top of the address range
    send_header(good_header(MAX_W, MAX_H, 1'b1, 1'b0, 0));
    send_prefix(0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (2) send_byte(8'($urandom), 1'b0);

    // widest single row with the longest ID field, cut short by a restart
    send_header(good_header(MAX_W, 1, 1'b0, 1'b1, 255));
    send_prefix(255);
    repeat (5) send_byte(8'($urandom), 1'b0);

    // size rejects, with bytes after a reject dropped
    send_header(good_header(0, 5, 1'b0, 1'b0, 0));
    send_header(good_header(5, 0, 1'b1, 1'b1, 0));
    send_header(good_header(MAX_W + 1, 1, 1'b0, 1'b1, 0));
    send_header(good_header(1, MAX_H + 1, 1'b1, 1'b0, 0));
    send_header(good_header(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 0));
    repeat (2) send_byte(8'($urandom), 1'b0);

    // format rejects, one field at a time; the last one also has a bad size
    for (int f = 0; f < 10; f++) begin
      hh = good_header(4, 4, $urandom_range(1), $urandom_range(1), 0);
      case (f)
        0: hh[HB_CMAP]     = 8'd0;
        1: hh[HB_TYPE]     = 8'd2;
        2: hh[HB_ORG_LO]   = 8'd1;
        3: hh[HB_ORG_HI]   = 8'h80;
        4: hh[HB_LEN_LO]   = 8'd15;
        5: hh[HB_LEN_HI]   = 8'd1;
        6: hh[HB_MAP_BITS] = 8'd32;
        7: hh[HB_PIX_BITS] = 8'd16;
        8: hh[HB_DESC]     = 8'd8;
        default: begin
          hh[HB_TYPE] = 8'd0;
          hh[HB_W_LO] = 8'd0;
          hh[HB_W_HI] = 8'd0;
        end
      endcase
      send_header(hh);
    end

    // restart inside a header, then inside the palette
    hh = good_header(2, 2, 1'b0, 1'b0, 0);
    send_byte(hh[0], 1'b1);
    for (int i = 1; i < 7; i++) send_byte(hh[i], 1'b0);
    send_header(good_header(2, 2, 1'b0, 1'b1, 0));
    repeat (20) send_byte(8'($urandom), 1'b0);
    wait_drained();

    // ---- random part: receiver-idle, sender-idle, then no idling ----
    sent_bytes = 0;
    while (sent_bytes < RAND_BYTES) begin
      if (sent_bytes >= 2 * RAND_BYTES / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (sent_bytes >= RAND_BYTES / 3) begin
        tx_idle = 74;
        rx_idle = 13;
      end
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      r = $urandom_range(99);
      if (r < 55) begin
        // complete file, sometimes with bytes past the end
        npix = w * h + $urandom_range(0, 3);
        send_file(w, h, $urandom_range(1), $urandom_range(1),
                  ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0, npix);
      end else if (r < 70) begin
        // truncated file; the next start drops it
        npix = $urandom_range(0, w * h - 1);
        send_file(w, h, $urandom_range(1), $urandom_range(1), 0, npix);
      end else if (r < 85) begin
        // corrupted header: a checked field, a size byte or everything
        hh = good_header(w, h, $urandom_range(1), $urandom_range(1), 0);
        case ($urandom_range(2))
          0: hh[$urandom_range(HB_CMAP, HB_MAP_BITS)] = 8'($urandom);
          1: hh[$urandom_range(HB_W_LO, HB_H_HI)]     = 8'($urandom);
          default: foreach (hh[i]) hh[i] = 8'($urandom);
        endcase
        send_header(hh);
      end else if (r < 95) begin
        // partial header
        hh = good_header(w, h, $urandom_range(1), $urandom_range(1), 0);
        send_byte(hh[0], 1'b1);
        for (int i = 1; i < $urandom_range(2, HDR_LEN - 1); i++) send_byte(hh[i], 1'b0);
      end else begin
        // loose bytes
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(3) == 0) wait_drained();
    end

    // ---- drain and report ----
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
